// ===== rtl/core/roll_pitch_complementary_filter_macros.svh =====
// Assertion macros shared by the filter RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef ROLL_PITCH_COMPLEMENTARY_FILTER_MACROS_SVH
`define ROLL_PITCH_COMPLEMENTARY_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define RPCF_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rpcf assertion failed");
`define RPCF_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rpcf assertion failed");
`else
`define RPCF_ASSERT_SAME(label, pre, post)
`define RPCF_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/core/rpcf_pkg.sv =====
// Types, constants and the arctangent table of the roll and pitch filter.
// Depends on nothing; used by the cell, the chain, the fusion and the top module.
package rpcf_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN = 24;
   localparam int X_W = 34;
   localparam int ACC_W = 27;
   localparam int TAB_W = 22;
   localparam int ANG_W = 19;
   localparam int ANGLE_W = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int LANE_ROLL = 0;
   localparam int LANE_PITCH = 1;

   localparam logic signed [ACC_W-1:0] HALF_TURN = 27'sd11796480;

   localparam logic [15:0] ALPHA_RESET = 16'd64881;
   localparam logic [19:0] FALLBACK_RESET = 20'd20000;
   localparam logic [23:0] MAX_INTERVAL_RESET = 24'd1000000;

   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -24'sh800000;

   // Quotient by 15625 is (u * DIV_RECIP) >> DIV_SHIFT, exact for u below DIV_LIMIT.
   localparam logic [35:0] DIV_RECIP = 36'd36028797019;
   localparam int DIV_SHIFT = 49;
   localparam logic [44:0] DIV_LIMIT = 45'd262144000000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALPHA = 2'd0,
      CSR_FALLBACK = 2'd1,
      CSR_MAX_INTERVAL = 2'd2
   } rpcf_csr_type;

   typedef struct packed {
      logic signed [X_W-1:0] x;
      logic signed [X_W-1:0] y;
      logic signed [ACC_W-1:0] acc;
      logic zero;
   } rpcf_lane_type;

   function automatic logic [TAB_W-1:0] rpcf_atan(input int idx);
      logic [TAB_W-1:0] v;
      unique case (idx)
         0: v = 22'd2949120;
         1: v = 22'd1740967;
         2: v = 22'd919879;
         3: v = 22'd466945;
         4: v = 22'd234379;
         5: v = 22'd117304;
         6: v = 22'd58666;
         7: v = 22'd29335;
         8: v = 22'd14668;
         9: v = 22'd7334;
         10: v = 22'd3667;
         11: v = 22'd1833;
         12: v = 22'd917;
         13: v = 22'd458;
         14: v = 22'd229;
         15: v = 22'd115;
         16: v = 22'd57;
         17: v = 22'd29;
         18: v = 22'd14;
         19: v = 22'd7;
         20: v = 22'd4;
         21: v = 22'd2;
         22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/rpcf_req_if.sv =====
// Input channel of the filter: sensor sample with valid and ready.
// Depends on nothing.
interface rpcf_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] roll_rate;
   logic signed [15:0] pitch_rate;
   logic [23:0] elapsed_us;

   modport source (output valid, accel_x, accel_y, accel_z, roll_rate, pitch_rate,
      elapsed_us, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, roll_rate, pitch_rate,
      elapsed_us, output ready);
endinterface

// ===== rtl/core/rpcf_rsp_if.sv =====
// Result channel of the filter: fused angles with valid and ready.
// Depends on nothing.
interface rpcf_rsp_if;
   logic valid;
   logic ready;
   logic signed [23:0] roll_out;
   logic signed [23:0] pitch_out;
   logic first_sample;

   modport source (output valid, roll_out, pitch_out, first_sample, input ready);
   modport sink (input valid, roll_out, pitch_out, first_sample, output ready);
endinterface

// ===== rtl/core/rpcf_cordic_cell.sv =====
// One vectoring CORDIC iteration for the roll and pitch lanes, registered.
// Depends on rpcf_pkg for the lane type and the arctangent table.
module rpcf_cordic_cell #(
   parameter int STEP = 0
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   input rpcf_pkg::rpcf_lane_type [1:0] lane_in,
   output logic out_valid,
   output rpcf_pkg::rpcf_lane_type [1:0] lane_out
);
   import rpcf_pkg::*;

   localparam logic signed [ACC_W-1:0] ANGLE_STEP = ACC_W'(rpcf_atan(STEP));

   rpcf_lane_type [1:0] lane_in_w;
   rpcf_lane_type [1:0] lane_ff;
   logic valid_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         lane_in_w[l].zero = lane_in[l].zero;
         if (lane_in[l].y >= 0) begin
            lane_in_w[l].x = lane_in[l].x + (lane_in[l].y >>> STEP);
            lane_in_w[l].y = lane_in[l].y - (lane_in[l].x >>> STEP);
            lane_in_w[l].acc = lane_in[l].acc + ANGLE_STEP;
         end else begin
            lane_in_w[l].x = lane_in[l].x - (lane_in[l].y >>> STEP);
            lane_in_w[l].y = lane_in[l].y + (lane_in[l].x >>> STEP);
            lane_in_w[l].acc = lane_in[l].acc - ANGLE_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      lane_ff <= lane_in_w;
   end

   assign out_valid = valid_ff;
   assign lane_out = lane_ff;

endmodule

// ===== rtl/core/rpcf_cordic_chain.sv =====
// Entry stage and row of CORDIC cells giving both accelerometer angles.
// Depends on rpcf_pkg and rpcf_cordic_cell.
module rpcf_cordic_chain #(
   parameter int STEPS = rpcf_pkg::CORDIC_STEPS_DEF
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   input logic signed [15:0] accel_x,
   input logic signed [15:0] accel_y,
   input logic signed [15:0] accel_z,
   output logic out_valid,
   output logic signed [rpcf_pkg::ANG_W-1:0] roll_angle,
   output logic signed [rpcf_pkg::ANG_W-1:0] pitch_angle
);
   import rpcf_pkg::*;

   localparam int NUM_CELLS = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

   logic valid_w [NUM_CELLS+1];
   rpcf_lane_type [1:0] lanes_w [NUM_CELLS+1];
   logic valid0_ff;
   rpcf_lane_type [1:0] lanes0_ff;
   logic signed [ACC_W-1:0] rounded [2];
   logic signed [ANG_W-1:0] angle [2];

   function automatic rpcf_lane_type prep_lane(input logic signed [15:0] num,
                                               input logic signed [15:0] den);
      rpcf_lane_type l;
      logic signed [X_W-1:0] xs;
      logic signed [X_W-1:0] ys;
      xs = X_W'(den) <<< 14;
      ys = X_W'(num) <<< 14;
      l.zero = (num == 16'sd0) && (den == 16'sd0);
      if (xs < 0) begin
         l.acc = (ys >= 0) ? HALF_TURN : -HALF_TURN;
         l.x = -xs;
         l.y = -ys;
      end else begin
         l.acc = '0;
         l.x = xs;
         l.y = ys;
      end
      return l;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= in_valid;
      end
      lanes0_ff[LANE_ROLL] <= prep_lane(accel_y, accel_z);
      lanes0_ff[LANE_PITCH] <= prep_lane(accel_x, accel_z);
   end

   assign valid_w[0] = valid0_ff;
   assign lanes_w[0] = lanes0_ff;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      rpcf_cordic_cell #(
         .STEP(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .in_valid(valid_w[i]),
         .lane_in(lanes_w[i]),
         .out_valid(valid_w[i+1]),
         .lane_out(lanes_w[i+1])
      );
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rounded[l] = lanes_w[NUM_CELLS][l].acc + ACC_W'(128);
         angle[l] = lanes_w[NUM_CELLS][l].zero ? '0 : ANG_W'(rounded[l] >>> 8);
      end
   end

   assign out_valid = valid_w[NUM_CELLS];
   assign roll_angle = angle[LANE_ROLL];
   assign pitch_angle = angle[LANE_PITCH];

endmodule

// ===== rtl/core/rpcf_fuse.sv =====
// Fusion of one axis: weighted sum of gyro prediction and accelerometer
// angle, rounded, divided by reciprocal multiplication and saturated. Uses rpcf_pkg.
module rpcf_fuse (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [15:0] alpha,
   input logic signed [rpcf_pkg::ANGLE_W-1:0] prev,
   input logic signed [15:0] rate,
   input logic [23:0] dt,
   input logic signed [rpcf_pkg::ANG_W-1:0] accel,
   output logic done,
   output logic signed [rpcf_pkg::ANGLE_W-1:0] result
);
   import rpcf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SUM, S_SPLIT, S_ACCUM, S_PREP, S_LOAD, S_DIV, S_FIN
   } state_type;

   state_type state_ff;
   logic signed [40:0] m1_ff;
   logic signed [40:0] m2_ff;
   logic signed [35:0] m3_ff;
   logic signed [41:0] s_ff;
   logic signed [52:0] m4_ff;
   logic [36:0] pl_ff;
   logic signed [37:0] ph_ff;
   logic signed [61:0] num_ff;
   logic neg_ff;
   logic [44:0] u_ff;
   logic big_ff;
   logic [36:0] pp_hh_ff;
   logic [36:0] pp_hl_ff;
   logic [36:0] pp_lh_ff;
   logic [36:0] pp_ll_ff;
   logic [23:0] quot_ff;
   logic done_ff;
   logic signed [ANGLE_W-1:0] result_ff;

   logic [16:0] weight;
   logic signed [43:0] q0;
   logic [73:0] prod;
   logic [24:0] qmag;
   logic signed [25:0] qs;
   logic signed [ANGLE_W-1:0] sat;

   always_comb begin
      weight = 17'h10000 - {1'b0, alpha};
      q0 = 44'(num_ff >>> 18);
      prod = (74'(pp_hh_ff) << 37) + (74'(pp_hl_ff) << 19) + (74'(pp_lh_ff) << 18)
         + 74'(pp_ll_ff);
      qmag = big_ff ? 25'h1000000 : {1'b0, quot_ff};
      qs = neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      if (qs > 26'(ANGLE_MAX)) begin
         sat = ANGLE_MAX;
      end else if (qs < 26'(ANGLE_MIN)) begin
         sat = ANGLE_MIN;
      end else begin
         sat = ANGLE_W'(qs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  m1_ff <= 41'(prev) * 41'sd62500;
                  m2_ff <= 41'(rate) * $signed({17'd0, dt});
                  m3_ff <= $signed({19'd0, weight}) * 36'(accel);
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               s_ff <= 42'(m1_ff) + 42'(m2_ff);
               m4_ff <= 53'(m3_ff) * 53'sd62500;
               state_ff <= S_SPLIT;
            end
            S_SPLIT: begin
               pl_ff <= {21'd0, alpha} * {16'd0, s_ff[20:0]};
               ph_ff <= $signed({22'd0, alpha}) * 38'($signed(s_ff[41:21]));
               state_ff <= S_ACCUM;
            end
            S_ACCUM: begin
               num_ff <= (62'(ph_ff) <<< 21) + $signed({25'd0, pl_ff}) + 62'(m4_ff)
                  + 62'sd2048000000;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               neg_ff <= q0 < 0;
               u_ff <= (q0 < 0) ? 45'(45'sd15624 - 45'(q0)) : 45'(q0);
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               big_ff <= u_ff >= DIV_LIMIT;
               pp_hh_ff <= 37'(u_ff[37:19]) * 37'(DIV_RECIP[35:18]);
               pp_hl_ff <= 37'(u_ff[37:19]) * 37'(DIV_RECIP[17:0]);
               pp_lh_ff <= 37'(u_ff[18:0]) * 37'(DIV_RECIP[35:18]);
               pp_ll_ff <= 37'(u_ff[18:0]) * 37'(DIV_RECIP[17:0]);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               quot_ff <= prod[DIV_SHIFT+23:DIV_SHIFT];
               state_ff <= S_FIN;
            end
            S_FIN: begin
               result_ff <= sat;
               done_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign result = result_ff;

endmodule

// ===== rtl/core/roll_pitch_complementary_filter.sv =====
// From input transfer, the first item after reset passes the entry stage and the cell row
// and gives its accelerometer angles; a fused item also passes fusion states S_SUM to S_FIN.
// One item in flight: the next input transfer comes at the earliest in the cycle after the
// result transfer, so the cell row and the fusion never hold more than one item.
// Reset (synchronous, active high) restores default registers and forgets the angles.
// Depends on rpcf_pkg, both channel interfaces, rpcf_cordic_chain and rpcf_fuse.
`include "roll_pitch_complementary_filter_macros.svh"
module roll_pitch_complementary_filter #(
   parameter int CORDIC_STEPS = rpcf_pkg::CORDIC_STEPS_DEF
) (
   input logic clock,
   input logic reset,
   rpcf_req_if.sink req_channel,
   rpcf_rsp_if.source rsp_channel,
   input logic csr_write_enable,
   input logic [rpcf_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [rpcf_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import rpcf_pkg::*;

   logic [15:0] alpha_ff;
   logic [19:0] fallback_ff;
   logic [23:0] max_ff;
   logic busy_ff;
   logic started_ff;
   logic signed [ANGLE_W-1:0] roll_ff;
   logic signed [ANGLE_W-1:0] pitch_ff;
   logic signed [15:0] roll_rate_ff;
   logic signed [15:0] pitch_rate_ff;
   logic [23:0] dt_ff;
   logic rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_roll_ff;
   logic signed [ANGLE_W-1:0] rsp_pitch_ff;
   logic rsp_first_ff;

   logic req_transfer;
   logic rsp_transfer;
   logic chain_valid;
   logic signed [ANG_W-1:0] acc_roll;
   logic signed [ANG_W-1:0] acc_pitch;
   logic fuse_start;
   logic roll_done;
   logic pitch_done;
   logic signed [ANGLE_W-1:0] roll_res;
   logic signed [ANGLE_W-1:0] pitch_res;

   assign req_transfer = req_channel.valid && req_channel.ready;
   assign rsp_transfer = rsp_channel.valid && rsp_channel.ready;
   assign fuse_start = chain_valid && started_ff;

   rpcf_cordic_chain #(
      .STEPS(CORDIC_STEPS)
   ) u_chain (
      .clock(clock),
      .reset(reset),
      .in_valid(req_transfer),
      .accel_x(req_channel.accel_x),
      .accel_y(req_channel.accel_y),
      .accel_z(req_channel.accel_z),
      .out_valid(chain_valid),
      .roll_angle(acc_roll),
      .pitch_angle(acc_pitch)
   );

   rpcf_fuse u_fuse_roll (
      .clock(clock),
      .reset(reset),
      .start(fuse_start),
      .alpha(alpha_ff),
      .prev(roll_ff),
      .rate(roll_rate_ff),
      .dt(dt_ff),
      .accel(acc_roll),
      .done(roll_done),
      .result(roll_res)
   );

   rpcf_fuse u_fuse_pitch (
      .clock(clock),
      .reset(reset),
      .start(fuse_start),
      .alpha(alpha_ff),
      .prev(pitch_ff),
      .rate(pitch_rate_ff),
      .dt(dt_ff),
      .accel(acc_pitch),
      .done(pitch_done),
      .result(pitch_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         fallback_ff <= FALLBACK_RESET;
         max_ff <= MAX_INTERVAL_RESET;
      end else if (csr_write_enable) begin
         unique case (rpcf_csr_type'(csr_index))
            CSR_ALPHA: alpha_ff <= csr_write_data[15:0];
            CSR_FALLBACK: fallback_ff <= csr_write_data[19:0];
            CSR_MAX_INTERVAL: max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         roll_rate_ff <= req_channel.roll_rate;
         pitch_rate_ff <= req_channel.pitch_rate;
         dt_ff <= (req_channel.elapsed_us == 24'd0 || req_channel.elapsed_us > max_ff) ?
            24'(fallback_ff) : req_channel.elapsed_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         started_ff <= 1'b0;
         roll_ff <= '0;
         pitch_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_transfer) begin
            busy_ff <= 1'b1;
         end else if (rsp_transfer) begin
            busy_ff <= 1'b0;
         end
         if (rsp_transfer) begin
            rsp_valid_ff <= 1'b0;
         end
         if (chain_valid && !started_ff) begin
            started_ff <= 1'b1;
            roll_ff <= ANGLE_W'(acc_roll);
            pitch_ff <= ANGLE_W'(acc_pitch);
            rsp_roll_ff <= ANGLE_W'(acc_roll);
            rsp_pitch_ff <= ANGLE_W'(acc_pitch);
            rsp_first_ff <= 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (roll_done) begin
            roll_ff <= roll_res;
            pitch_ff <= pitch_res;
            rsp_roll_ff <= roll_res;
            rsp_pitch_ff <= pitch_res;
            rsp_first_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   assign req_channel.ready = !busy_ff;
   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.roll_out = rsp_roll_ff;
   assign rsp_channel.pitch_out = rsp_pitch_ff;
   assign rsp_channel.first_sample = rsp_first_ff;

   `RPCF_ASSERT_SAME(a_fuse_lockstep, 1'b1, roll_done == pitch_done)
   `RPCF_ASSERT_SAME(a_chain_while_busy, chain_valid, busy_ff && !rsp_valid_ff)
   `RPCF_ASSERT_SAME(a_done_while_busy, roll_done, busy_ff && !rsp_valid_ff && started_ff)
   `RPCF_ASSERT_NEXT(a_result_then_idle, rsp_transfer, req_channel.ready)

endmodule
